// ===== rtl/fixed_point_format_converter_top_macros.svh =====
// Assertion helpers for the format converter.
`ifndef FIXED_POINT_FORMAT_CONVERTER_TOP_MACROS_SVH
`define FIXED_POINT_FORMAT_CONVERTER_TOP_MACROS_SVH

// Assert an implication on every clock edge outside reset.
`define FPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that the consequent holds on the clock edge after the antecedent, outside reset.
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fpc_pkg;
    localparam int FRACTION_BITS_DEF = 8;

    localparam logic [1:0] OP_INT_TO_FIX   = 2'd0;
    localparam logic [1:0] OP_FLT_TO_FIX   = 2'd1;
    localparam logic [1:0] OP_FIX_TO_FLT   = 2'd2;
    localparam logic [1:0] OP_FIX_TO_INT   = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_word;
        logic        overflow;
    } t_out_item;
endpackage
`default_nettype wire

// ===== rtl/fixed_point_format_converter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | i_in_valid/o_in_stall  | fpc_pkg::t_in_item
// out     | output    | o_out_valid/i_out_stall | fpc_pkg::t_out_item
// One transaction enters per cycle while the input is not stalled; each passes through the
// decode, magnitude shift, rounding and sign/pack stages to the output register.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// A stall on the output holds every full stage with no empty stage after it; bubbles are squeezed out, so the
// input stalls only when every stage holds a transaction and the output is stalled.
module fixed_point_format_converter_top #(
    parameter int FRACTION_BITS = fpc_pkg::FRACTION_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire fpc_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output fpc_pkg::t_out_item  o_out_data
);
    import fpc_pkg::*;

    localparam logic [5:0] FB = 6'(FRACTION_BITS);

    // ---------------- stage valids and advance ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv4, adv3, adv2, adv1;
    assign adv4 = !r_v4 || !i_out_stall;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_in_stall = !adv1;

    // ---------------- stage 1: decode ----------------
    // Every path is reduced to: sign, a 32-bit magnitude, a shift (left or right)
    // and special flags.
    logic        n_neg, n_sat, n_nan, n_zero, n_left;
    logic [31:0] n_mag;
    logic [6:0]  n_sh;
    logic [1:0]  n_op;
    logic [5:0]  n_p;

    logic        r1_neg, r1_sat, r1_nan, r1_zero, r1_left;
    logic [31:0] r1_mag;
    logic [6:0]  r1_sh;
    logic [1:0]  r1_op;
    logic [5:0]  r1_p;
    logic [31:0] r1_raw;

    logic [7:0]  f_e;
    logic [23:0] f_sig;
    logic signed [9:0] f_ex;
    logic [31:0] x;

    always_comb begin
        x      = i_in_data.operand;
        n_op   = i_in_data.operation;
        n_neg  = x[31];
        n_sat  = 1'b0;
        n_nan  = 1'b0;
        n_zero = 1'b0;
        n_left = 1'b1;
        n_mag  = x[31] ? (32'd0 - x) : x;
        n_sh   = {1'b0, FB};
        n_p    = 6'd0;
        f_e    = x[30:23];
        f_sig  = (f_e == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
        f_ex   = ((f_e == 8'd0) ? -10'sd149 : ($signed({2'b00, f_e}) - 10'sd150))
                 + $signed({4'd0, FB});
        case (n_op)
            OP_FLT_TO_FIX: begin
                n_mag = {8'd0, f_sig};
                if (f_e == 8'hFF) begin
                    n_nan = (x[22:0] != 23'd0);
                    n_sat = (x[22:0] == 23'd0);
                end else if (f_sig == 24'd0) begin
                    n_zero = 1'b1;
                end else if (f_ex >= 10'sd32) begin
                    n_sat = 1'b1;
                end else if (f_ex >= 10'sd0) begin
                    n_sh = f_ex[6:0];
                end else begin
                    n_left = 1'b0;
                    if (f_ex <= -10'sd26) begin
                        n_zero = 1'b1;
                    end else begin
                        n_sh = 7'(-f_ex);
                    end
                end
            end
            OP_FIX_TO_FLT: begin
                n_zero = (n_mag == 32'd0);
                for (int i = 0; i < 32; i++) begin
                    if (n_mag[i]) n_p = 6'(i);
                end
                n_left = (n_p <= 6'd23);
                n_sh   = n_left ? 7'(6'd23 - n_p) : 7'(n_p - 6'd23);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= i_in_valid;
        end
        if (adv1) begin
            r1_neg <= n_neg;   r1_sat <= n_sat;   r1_nan <= n_nan;
            r1_zero <= n_zero; r1_left <= n_left;
            r1_mag <= n_mag;   r1_sh <= n_sh;     r1_op <= n_op;
            r1_p <= n_p;       r1_raw <= x;
        end
    end

    // ---------------- stage 2: shift ----------------
    // Left shifts keep 64 bits for range checks; right shifts keep the half bit
    // for float to fixed and round/sticky bits for fixed to float.
    logic [63:0] s2_left;
    logic [31:0] s2_right;
    logic        s2_half, s2_sticky;
    logic [63:0] r2_lsh;
    logic [31:0] r2_right;
    logic        r2_half, r2_sticky;
    logic        r2_neg, r2_sat, r2_nan, r2_zero, r2_left;
    logic [1:0]  r2_op;
    logic [5:0]  r2_p;
    logic [31:0] r2_raw;
    logic [31:0] low_mask;

    always_comb begin
        s2_left  = {32'd0, r1_mag} << r1_sh;
        s2_right = r1_mag >> r1_sh;
        low_mask = (r1_sh == 7'd0) ? 32'd0 : ((32'd1 << (r1_sh - 7'd1)) - 32'd1);
        s2_half  = (r1_sh == 7'd0) ? 1'b0 : r1_mag[5'(r1_sh - 7'd1)];
        s2_sticky = (r1_mag & low_mask) != 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
        if (adv2) begin
            r2_lsh <= s2_left;    r2_right <= s2_right;
            r2_half <= s2_half;   r2_sticky <= s2_sticky;
            r2_neg <= r1_neg;     r2_sat <= r1_sat;   r2_nan <= r1_nan;
            r2_zero <= r1_zero;   r2_left <= r1_left; r2_op <= r1_op;
            r2_p <= r1_p;         r2_raw <= r1_raw;
        end
    end

    // ---------------- stage 3: round and range ----------------
    logic [32:0] n3_mag;
    logic [5:0]  n3_p;
    logic        n3_sat;
    logic [31:0] r3_mag;
    logic [5:0]  r3_p;
    logic        r3_neg, r3_sat, r3_nan, r3_zero;
    logic [1:0]  r3_op;
    logic [31:0] r3_raw;
    logic [63:0] m64;
    logic [24:0] keep;

    function automatic logic [23:0] r2_left_word(input logic [63:0] v);
        return v[23:0];
    endfunction

    always_comb begin
        n3_p   = r2_p;
        n3_sat = r2_sat;
        keep   = 25'd0;
        m64    = 64'd0;
        n3_mag = 33'd0;
        case (r2_op)
            OP_FIX_TO_FLT: begin
                if (r2_left) begin
                    n3_mag = {9'd0, r2_left_word(r2_lsh)};
                end else begin
                    keep = {1'b0, r2_right[23:0]};
                    if (r2_half && (r2_sticky || r2_right[0])) keep = keep + 25'd1;
                    if (keep[24]) begin
                        keep = keep >> 1;
                        n3_p = r2_p + 6'd1;
                    end
                    n3_mag = {8'd0, keep};
                end
            end
            default: begin
                if (r2_left) begin
                    m64 = r2_lsh;
                end else begin
                    m64 = {32'd0, r2_right} + {63'd0, r2_half};
                end
                if (r2_zero || r2_nan) m64 = 64'd0;
                if (r2_neg ? (m64 > 64'h8000_0000) : (m64 > 64'h7FFF_FFFF)) n3_sat = 1'b1;
                n3_mag = m64[32:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
        if (adv3) begin
            r3_mag <= n3_mag[31:0]; r3_p <= n3_p;   r3_sat <= n3_sat;
            r3_neg <= r2_neg;       r3_nan <= r2_nan; r3_zero <= r2_zero;
            r3_op <= r2_op;         r3_raw <= r2_raw;
        end
    end

    // ---------------- stage 4: sign, pack, saturate ----------------
    t_out_item n4, r4;
    logic [7:0] exp_f;

    always_comb begin
        n4.overflow    = 1'b0;
        n4.result_word = 32'd0;
        exp_f = 8'(r3_p + 8'd127 - {2'd0, FB});
        case (r3_op)
            OP_FIX_TO_INT: begin
                n4.result_word = 32'($signed(r3_raw) >>> FB);
            end
            OP_FIX_TO_FLT: begin
                n4.result_word = r3_zero ? 32'd0 : {r3_neg, exp_f, r3_mag[22:0]};
            end
            default: begin
                if (r3_nan) begin
                    n4.overflow = 1'b1;
                end else if (r3_sat) begin
                    n4.overflow    = 1'b1;
                    n4.result_word = r3_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n4.result_word = r3_neg ? (32'd0 - r3_mag) : r3_mag;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv4) begin
            r_v4 <= r_v3;
        end
        if (adv4) begin
            r4 <= n4;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r4;

    `include "fixed_point_format_converter_top_macros.svh"

    `FPC_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_v4 && i_out_stall, r_v4 && $stable(r4), "output changed under stall")
    `FPC_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall, r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall, "input stalled with room")
    `FPC_ASSERT_IMP(a_ovf_ops, i_clk, i_rst_n, r_v4 && r4.overflow, r_v4, "overflow without item")
endmodule
`default_nettype wire
